### hdl/csfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the CAN signal field decoder.
// No dependencies; every other file of the block imports this package.
package csfd_pkg;

  // Fraction bits of the fixed-point factor and bias
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned FACT_W  = 32;
  localparam int unsigned BIAS_W  = 48;
  localparam int unsigned SUM_W   = DATA_W + FACT_W + 1;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_BYTE_ORDER     = 3'd0,
    REG_ANCHOR_BIT     = 3'd1,
    REG_ANCHOR_BYTE    = 3'd2,
    REG_FIELD_LEN      = 3'd3,
    REG_FRAME_LEN      = 3'd4,
    REG_SIGN_FILL_MASK = 3'd5,
    REG_SCALE_FACTOR   = 3'd6,
    REG_OFFSET_BIAS    = 3'd7
  } reg_idx_e;

  // Byte order codes
  typedef enum logic {
    ORDER_INTEL    = 1'b0,
    ORDER_MOTOROLA = 1'b1
  } byte_order_e;

  // Configuration register set
  typedef struct packed {
    byte_order_e        byte_order;
    logic [5:0]         anchor_bit;
    logic [2:0]         anchor_byte;
    logic [6:0]         field_len;
    logic [3:0]         frame_len;
    logic [63:0]        sign_fill_mask;
    logic signed [31:0] scale_factor;
    logic signed [47:0] offset_bias;
  } cfg_t;

  // Pipeline stage control
  typedef struct packed {
    logic adv;    // all stages advance this cycle
    logic valid;  // word entering the stage is real
  } stage_ctl_t;

endpackage

### hdl/csfd_extract.sv
`timescale 1ns / 1ps
// Field extraction stage: byte-order assembly, field cut and sign fill.
// Depends on csfd_pkg for the configuration struct and codes.
module csfd_extract (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csfd_pkg::stage_ctl_t ctl_i,
  input  csfd_pkg::cfg_t      cfg_i,
  input  logic [63:0]         data_i,
  output logic                valid_o,
  output logic [63:0]         raw_o
);
  import csfd_pkg::*;

  logic [3:0]  n_bytes;
  logic [6:0]  len;
  logic [63:0] len_mask;
  logic [63:0] byte_mask;
  logic [63:0] intel_field;
  logic [63:0] rev_data;
  logic [63:0] moto_word;
  logic [3:0]  msb_byte;
  logic [5:0]  msb;
  logic [7:0]  lsb;
  logic [7:0]  lsb_neg;
  logic [63:0] moto_field;
  logic [63:0] field;
  logic [5:0]  len_m1;
  logic [63:0] raw_d;
  logic [63:0] raw_q;
  logic        valid_q;

  // Clamp lengths and build masks
  always_comb begin
    n_bytes   = (cfg_i.frame_len > 4'd8) ? 4'd8 : cfg_i.frame_len;
    len       = (cfg_i.field_len > 7'd64) ? 7'd64 : cfg_i.field_len;
    len_mask  = (len == 7'd0) ? '0 : ({64{1'b1}} >> (7'd64 - len));
    byte_mask = {64{1'b1}} >> (7'd64 - {n_bytes[3:0], 3'b000});
  end

  // Intel: little-endian word, LSB at start bit
  assign intel_field = ((data_i & byte_mask) >> cfg_i.anchor_bit) & len_mask;

  // Motorola: reverse the bytes, then drop the unused tail bytes
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rev_data[8*(7-i) +: 8] = data_i[8*i +: 8];
    end
    moto_word  = rev_data >> (7'd64 - {n_bytes[3:0], 3'b000});
    msb_byte   = n_bytes - 4'd1 - {1'b0, cfg_i.anchor_byte};
    msb        = {msb_byte[2:0], cfg_i.anchor_bit[2:0]};
    lsb        = {2'b00, msb} - {1'b0, len} + 8'd1;
    lsb_neg    = 8'd0 - lsb;
    if (lsb[7]) begin
      moto_field = (moto_word << lsb_neg[5:0]) & len_mask;
    end else begin
      moto_field = (moto_word >> lsb[5:0]) & len_mask;
    end
  end

  // Pick the layout; empty frame or empty field give zero, as does a Motorola start byte past the frame
  always_comb begin
    if (len == 7'd0 || n_bytes == 4'd0) begin
      field = '0;
    end else if (cfg_i.byte_order == ORDER_INTEL) begin
      field = intel_field;
    end else if ({1'b0, cfg_i.anchor_byte} >= n_bytes) begin
      field = '0;
    end else begin
      field = moto_field;
    end
  end

  // OR in the sign fill when the field's top bit is set
  always_comb begin
    len_m1 = 6'(len - 7'd1);
    raw_d  = field;
    if (len != 7'd0 && field[len_m1]) begin
      raw_d = field | cfg_i.sign_fill_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.adv) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      raw_q <= raw_d;
    end
  end

  assign valid_o = valid_q;
  assign raw_o   = raw_q;

endmodule

### hdl/csfd_mult.sv
`timescale 1ns / 1ps
// Scaling multiply stage: raw value times factor as two partial products over the 32-bit halves of the raw value.
// Depends on csfd_pkg for the stage control struct.
module csfd_mult (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  csfd_pkg::stage_ctl_t ctl_i,
  input  logic signed [31:0]   factor_i,
  input  logic [63:0]          raw_i,
  output logic                 valid_o,
  output logic [63:0]          raw_o,
  output logic signed [64:0]   prod_lo_o,
  output logic signed [63:0]   prod_hi_o
);
  import csfd_pkg::*;

  logic signed [64:0] prod_lo_d;
  logic signed [63:0] prod_hi_d;
  logic signed [64:0] prod_lo_q;
  logic signed [63:0] prod_hi_q;
  logic [63:0]        raw_q;
  logic               valid_q;

  // Low half is unsigned, high half carries the sign
  always_comb begin
    prod_lo_d = $signed({1'b0, raw_i[31:0]}) * factor_i;
    prod_hi_d = $signed(raw_i[63:32]) * factor_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.adv) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      prod_lo_q <= prod_lo_d;
      prod_hi_q <= prod_hi_d;
      raw_q     <= raw_i;
    end
  end

  assign valid_o   = valid_q;
  assign raw_o     = raw_q;
  assign prod_lo_o = prod_lo_q;
  assign prod_hi_o = prod_hi_q;

endmodule

### hdl/csfd_scale.sv
`timescale 1ns / 1ps
// Bias add and saturation stage; holds the output word register.
// Depends on csfd_pkg for widths and the stage control struct.
module csfd_scale (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  csfd_pkg::stage_ctl_t ctl_i,
  input  logic signed [47:0]   bias_i,
  input  logic [63:0]          raw_i,
  input  logic signed [64:0]   prod_lo_i,
  input  logic signed [63:0]   prod_hi_i,
  output logic                 valid_o,
  output logic [63:0]          raw_o,
  output logic [63:0]          phys_o,
  output logic                 sat_o
);
  import csfd_pkg::*;

  logic [SUM_W-1:0] sum;
  logic             fits;
  logic [63:0]      phys_d;
  logic             sat_d;
  logic [63:0]      phys_q;
  logic [63:0]      raw_q;
  logic             sat_q;
  logic             valid_q;

  // Exact sum of both partial products and the bias
  always_comb begin
    sum = {prod_hi_i[63], prod_hi_i, 32'b0}
        + {{(SUM_W - 65){prod_lo_i[64]}}, prod_lo_i}
        + {{(SUM_W - BIAS_W){bias_i[47]}}, bias_i};
  end

  // Clip to the signed 64-bit range
  always_comb begin
    fits = (&sum[SUM_W-1:63]) | ~(|sum[SUM_W-1:63]);
    if (fits) begin
      phys_d = sum[63:0];
      sat_d  = 1'b0;
    end else begin
      phys_d = sum[SUM_W-1] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      sat_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.adv) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      phys_q <= phys_d;
      sat_q  <= sat_d;
      raw_q  <= raw_i;
    end
  end

  assign valid_o = valid_q;
  assign raw_o   = raw_q;
  assign phys_o  = phys_q;
  assign sat_o   = sat_q;

endmodule

### hdl/can_signal_field_decoder.sv
`timescale 1ns / 1ps
// CAN signal field decoder: top level with configuration registers,
// input register and pipeline control. Uses csfd_pkg, csfd_extract,
// csfd_mult and csfd_scale.
//
// Usage:
//   s_axis carries one word per CAN frame: the eight data bytes, byte i in
//   bits 8i+7..8i. m_axis returns one word per frame with the extracted raw
//   field, the scaled physical value (Q47.16) and a saturation flag.
//   The cfg port writes one register per cycle; the user must write it only
//   while the block is idle, which the block itself does not enforce.
//   cfg_addr_i selects byte_order, anchor_bit, anchor_byte, field_len,
//   frame_len, sign_fill_mask, scale_factor or offset_bias (0..7).
//   Throughput is one frame per cycle while the receiver does not stall. A
//   frame accepted on s_axis passes the input register, extraction register,
//   multiply register and output register before it is presented on m_axis.
//   The 64x32 multiply is split in two partial products so that stage stays
//   short. The four stages advance together; when the receiver stalls with
//   the output register full, the whole pipeline holds and s_axis_tready
//   drops until the output word is taken. Reset clears all valid flags and
//   loads the default configuration (Intel order, start bit 0, 8-bit signal,
//   8-byte frame, factor 1.0, no bias, no sign fill).
module can_signal_field_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [63:0]  cfg_wdata_i,
  // Frame input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // [63:0] frame_data
  // Decoded output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata    // [63:0] raw_value, [127:64] physical_value,
                                       // [128] saturated, [135:129] zero
);
  import csfd_pkg::*;

  cfg_t        cfg_q;
  logic [63:0] data_q;
  logic        in_valid_q;
  logic        adv;
  stage_ctl_t  ctl_ext;
  stage_ctl_t  ctl_mul;
  stage_ctl_t  ctl_scl;
  logic        ext_valid;
  logic [63:0] ext_raw;
  logic        mul_valid;
  logic [63:0] mul_raw;
  logic signed [64:0] mul_lo;
  logic signed [63:0] mul_hi;
  logic        out_valid;
  logic [63:0] out_raw;
  logic [63:0] out_phys;
  logic        out_sat;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.byte_order     <= ORDER_INTEL;
      cfg_q.anchor_bit     <= '0;
      cfg_q.anchor_byte    <= '0;
      cfg_q.field_len      <= 7'd8;
      cfg_q.frame_len      <= 4'd8;
      cfg_q.sign_fill_mask <= '0;
      cfg_q.scale_factor   <= 32'(1 << FRAC_BITS);
      cfg_q.offset_bias    <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_BYTE_ORDER:     cfg_q.byte_order     <= byte_order_e'(cfg_wdata_i[0]);
        REG_ANCHOR_BIT:     cfg_q.anchor_bit     <= cfg_wdata_i[5:0];
        REG_ANCHOR_BYTE:    cfg_q.anchor_byte    <= cfg_wdata_i[2:0];
        REG_FIELD_LEN:      cfg_q.field_len      <= cfg_wdata_i[6:0];
        REG_FRAME_LEN:      cfg_q.frame_len      <= cfg_wdata_i[3:0];
        REG_SIGN_FILL_MASK: cfg_q.sign_fill_mask <= cfg_wdata_i;
        REG_SCALE_FACTOR:   cfg_q.scale_factor   <= $signed(cfg_wdata_i[31:0]);
        REG_OFFSET_BIAS:    cfg_q.offset_bias    <= $signed(cfg_wdata_i[47:0]);
        default: ;
      endcase
    end
  end

  // Advance all stages unless a finished word is stuck at the output
  assign adv           = ~out_valid | m_axis_tready;
  assign s_axis_tready = adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      data_q <= s_axis_tdata;
    end
  end

  assign ctl_ext = '{adv: adv, valid: in_valid_q};
  assign ctl_mul = '{adv: adv, valid: ext_valid};
  assign ctl_scl = '{adv: adv, valid: mul_valid};

  csfd_extract u_extract (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_ext),
    .cfg_i   (cfg_q),
    .data_i  (data_q),
    .valid_o (ext_valid),
    .raw_o   (ext_raw)
  );

  csfd_mult u_mult (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_mul),
    .factor_i  (cfg_q.scale_factor),
    .raw_i     (ext_raw),
    .valid_o   (mul_valid),
    .raw_o     (mul_raw),
    .prod_lo_o (mul_lo),
    .prod_hi_o (mul_hi)
  );

  csfd_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_scl),
    .bias_i    (cfg_q.offset_bias),
    .raw_i     (mul_raw),
    .prod_lo_i (mul_lo),
    .prod_hi_i (mul_hi),
    .valid_o   (out_valid),
    .raw_o     (out_raw),
    .phys_o    (out_phys),
    .sat_o     (out_sat)
  );

  // Pack the output word
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_sat, out_phys, out_raw};

endmodule
